// ===== hw/rtl/hsv_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hsv_pkg
// Shared types, constants and helper functions of the HSV brightness block.
// ----------------------------------------------------------------------------
package hsv_pkg;

    // Hue sectors, red-yellow through magenta-red
    typedef enum logic [2:0] {
        SEC_RY = 3'd0,
        SEC_YG = 3'd1,
        SEC_GC = 3'd2,
        SEC_CB = 3'd3,
        SEC_BM = 3'd4,
        SEC_MR = 3'd5
    } t_sector;

    typedef enum logic {
        MODE_DARKEN  = 1'b0,
        MODE_LIGHTEN = 1'b1
    } t_mode;

    typedef enum logic {
        CFG_MODE  = 1'b0,
        CFG_RATIO = 1'b1
    } t_cfg_index;

    // 1.0 in value units: 255 with 12 fraction bits
    localparam logic [19:0] V_ONE  = 20'd1044480;
    // excess cap: anything at or above this clears saturation anyway
    localparam logic [23:0] X_CAP  = 24'd16711935;
    // ceil(2^32 / 255), exact for 24-bit dividends
    localparam logic [24:0] DIV255_M = 25'd16843010;
    localparam logic [16:0] Q16_ONE  = 17'd65536;

    typedef struct packed {
        t_sector     sec;
        logic [16:0] frac;
        logic [16:0] sat;
        logic [7:0]  mx;
        logic [23:0] adj;
        logic [7:0]  alpha;
    } t_hsv;

    typedef struct packed {
        t_sector     sec;
        logic [15:0] frac;
        logic [16:0] sat;
        logic [19:0] v;
        logic [7:0]  alpha;
    } t_hsv_adj;

    // one restoring division step: returns {quotient bit, new remainder}
    function automatic logic [8:0] div_step(input logic [7:0] rem, input logic [7:0] den);
        logic [8:0] t;
        t = {rem, 1'b0};
        if (t >= {1'b0, den}) begin
            div_step = {1'b1, 8'(t - {1'b0, den})};
        end else begin
            div_step = {1'b0, t[7:0]};
        end
    endfunction

    function automatic t_sector next_sector(input t_sector sec);
        case (sec)
            SEC_RY:  next_sector = SEC_YG;
            SEC_YG:  next_sector = SEC_GC;
            SEC_GC:  next_sector = SEC_CB;
            SEC_CB:  next_sector = SEC_BM;
            SEC_BM:  next_sector = SEC_MR;
            default: next_sector = SEC_RY;
        endcase
    endfunction

endpackage

// ===== hw/rtl/hsv_ifs.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hsv_in_if / hsv_out_if
// Valid/ready pixel channels into and out of the brightness block.
// ----------------------------------------------------------------------------
interface hsv_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_red;
    logic [7:0] in_green;
    logic [7:0] in_blue;
    logic [7:0] in_alpha;

    modport source (output valid, in_red, in_green, in_blue, in_alpha, input ready);
    modport sink   (input valid, in_red, in_green, in_blue, in_alpha, output ready);
endinterface

interface hsv_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_red;
    logic [7:0] out_green;
    logic [7:0] out_blue;
    logic [7:0] out_alpha;

    modport source (output valid, out_red, out_green, out_blue, out_alpha, input ready);
    modport sink   (input valid, out_red, out_green, out_blue, out_alpha, output ready);
endinterface

// ===== hw/rtl/hsv_div.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hsv_div
// Three-stage restoring divider: floor(num * 65536 / den) for num <= den.
// ----------------------------------------------------------------------------
module hsv_div (
    input  logic        i_clk,
    input  logic        i_en,
    input  logic [7:0]  i_num,
    input  logic [7:0]  i_den,
    output logic [16:0] o_quot
);

    logic [5:0]  r_q1, n_q1;
    logic [7:0]  r_rem1, n_rem1;
    logic [7:0]  r_den1;
    logic [11:0] r_q2, n_q2;
    logic [7:0]  r_rem2, n_rem2;
    logic [7:0]  r_den2;
    logic [16:0] r_q3, n_q3;

    // integer bit plus five fraction bits
    always_comb begin
        logic [8:0] st;
        n_rem1 = i_num;
        n_q1   = '0;
        if (i_num >= i_den) begin
            n_q1[0] = 1'b1;
            n_rem1  = i_num - i_den;
        end
        for (int k = 0; k < 5; k++) begin
            st     = hsv_pkg::div_step(n_rem1, i_den);
            n_q1   = {n_q1[4:0], st[8]};
            n_rem1 = st[7:0];
        end
    end

    always_comb begin
        logic [8:0] st;
        n_rem2 = r_rem1;
        n_q2   = {r_q1, 6'd0};
        for (int k = 0; k < 6; k++) begin
            st     = hsv_pkg::div_step(n_rem2, r_den1);
            n_q2   = {n_q2[10:0], st[8]};
            n_rem2 = st[7:0];
        end
        n_q2 = {r_q1, n_q2[5:0]};
    end

    always_comb begin
        logic [8:0] st;
        logic [4:0] q;
        logic [7:0] rem;
        rem = r_rem2;
        q   = '0;
        for (int k = 0; k < 5; k++) begin
            st  = hsv_pkg::div_step(rem, r_den2);
            q   = {q[3:0], st[8]};
            rem = st[7:0];
        end
        n_q3 = {r_q2, q};
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_q1   <= n_q1;
            r_rem1 <= n_rem1;
            r_den1 <= i_den;
            r_q2   <= n_q2;
            r_rem2 <= n_rem2;
            r_den2 <= r_den1;
            r_q3   <= n_q3;
        end
    end

    assign o_quot = r_q3;

endmodule

// ===== hw/rtl/hsv_rgb2hsv.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hsv_rgb2hsv
// Max/min and sector pick, then hue fraction and saturation by division.
// ----------------------------------------------------------------------------
module hsv_rgb2hsv (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_en,
    input  logic            i_valid,
    input  logic [7:0]      i_red,
    input  logic [7:0]      i_green,
    input  logic [7:0]      i_blue,
    input  logic [7:0]      i_alpha,
    input  logic [15:0]     i_ratio,
    output logic            o_valid,
    output hsv_pkg::t_hsv   o_hsv
);

    typedef struct packed {
        hsv_pkg::t_sector sec;
        logic [7:0]       mx;
        logic [7:0]       alpha;
    } t_side;

    logic [7:0]       mx, mn, d, num;
    hsv_pkg::t_sector sec;

    logic [7:0]  r_num_h, r_den_h, r_num_s, r_den_s;
    t_side       r_side [4];
    logic [23:0] r_adj  [3];
    logic [3:0]  r_valid;
    logic [16:0] frac, sat;

    always_comb begin
        mx = i_red;
        mn = i_red;
        if (i_green > mx) mx = i_green;
        if (i_blue > mx)  mx = i_blue;
        if (i_green < mn) mn = i_green;
        if (i_blue < mn)  mn = i_blue;
        d = mx - mn;
        if (d == 8'd0) begin
            sec = hsv_pkg::SEC_RY;
            num = 8'd0;
        end else if (mx == i_red) begin
            if (i_green >= i_blue) begin
                sec = hsv_pkg::SEC_RY;
                num = i_green - i_blue;
            end else begin
                sec = hsv_pkg::SEC_MR;
                num = d - (i_blue - i_green);
            end
        end else if (mx == i_green) begin
            if (i_blue >= i_red) begin
                sec = hsv_pkg::SEC_GC;
                num = i_blue - i_red;
            end else begin
                sec = hsv_pkg::SEC_YG;
                num = d - (i_red - i_blue);
            end
        end else begin
            if (i_red >= i_green) begin
                sec = hsv_pkg::SEC_BM;
                num = i_red - i_green;
            end else begin
                sec = hsv_pkg::SEC_CB;
                num = d - (i_green - i_red);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            // grey and black pixels divide 0 by 1 for hue, black ones also for saturation
            r_num_h   <= num;
            r_den_h   <= (d == 8'd0) ? 8'd1 : d;
            r_num_s   <= (mx == 8'd0) ? 8'd0 : d;
            r_den_s   <= (mx == 8'd0) ? 8'd1 : mx;
            r_side[0] <= '{sec: sec, mx: mx, alpha: i_alpha};
            for (int k = 1; k < 4; k++) begin
                r_side[k] <= r_side[k-1];
            end
            r_adj[0] <= 24'(r_side[0].mx * i_ratio);
            r_adj[1] <= r_adj[0];
            r_adj[2] <= r_adj[1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_en) begin
            r_valid <= {r_valid[2:0], i_valid};
        end
    end

    hsv_div u_div_hue (
        .i_clk  (i_clk),
        .i_en   (i_en),
        .i_num  (r_num_h),
        .i_den  (r_den_h),
        .o_quot (frac)
    );

    hsv_div u_div_sat (
        .i_clk  (i_clk),
        .i_en   (i_en),
        .i_num  (r_num_s),
        .i_den  (r_den_s),
        .o_quot (sat)
    );

    assign o_valid = r_valid[3];
    assign o_hsv   = '{sec: r_side[3].sec, frac: frac, sat: sat, mx: r_side[3].mx,
                       adj: r_adj[2], alpha: r_side[3].alpha};

endmodule

// ===== hw/rtl/hsv_vadj.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hsv_vadj
// Scale the value; in lighten mode trade the excess against saturation.
// ----------------------------------------------------------------------------
module hsv_vadj (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  logic              i_valid,
    input  hsv_pkg::t_hsv     i_hsv,
    input  hsv_pkg::t_mode    i_mode,
    output logic              o_valid,
    output hsv_pkg::t_hsv_adj o_adj
);

    hsv_pkg::t_hsv_adj r_p5, r_p6, r_p7, n_p5, n_p7;
    logic [23:0]       r_x5, n_x5;
    logic              r_over5, r_over6, n_over5;
    logic [16:0]       r_ex6;
    logic [48:0]       prod;
    logic [2:0]        r_valid;

    always_comb begin
        logic [19:0] v0;
        logic [24:0] vs;
        logic [24:0] xd;
        logic [28:0] x29;
        v0 = {i_hsv.mx, 12'd0};
        n_p5.alpha = i_hsv.alpha;
        n_p5.sat   = i_hsv.sat;
        // a fraction that reaches one rolls into the next sector
        if (i_hsv.frac[16]) begin
            n_p5.frac = 16'd0;
            n_p5.sec  = hsv_pkg::next_sector(i_hsv.sec);
        end else begin
            n_p5.frac = i_hsv.frac[15:0];
            n_p5.sec  = i_hsv.sec;
        end
        vs      = 25'(v0) + 25'(i_hsv.adj);
        xd      = vs - 25'(hsv_pkg::V_ONE);
        x29     = {xd, 4'd0};
        n_over5 = 1'b0;
        n_x5    = (x29 >= 29'(hsv_pkg::X_CAP)) ? hsv_pkg::X_CAP : x29[23:0];
        if (i_mode == hsv_pkg::MODE_DARKEN) begin
            n_p5.v = (i_hsv.adj >= 24'(v0)) ? 20'd0 : 20'(24'(v0) - i_hsv.adj);
        end else if (vs > 25'(hsv_pkg::V_ONE)) begin
            n_over5 = 1'b1;
            n_p5.v  = hsv_pkg::V_ONE;
        end else begin
            n_p5.v = vs[19:0];
        end
    end

    // divide excess by 255 with a reciprocal multiply
    assign prod = 49'(r_x5) * 49'(hsv_pkg::DIV255_M);

    always_comb begin
        n_p7 = r_p6;
        if (r_over6) begin
            n_p7.sat = (r_ex6 >= r_p6.sat) ? 17'd0 : r_p6.sat - r_ex6;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_p5    <= n_p5;
            r_x5    <= n_x5;
            r_over5 <= n_over5;
            r_p6    <= r_p5;
            r_ex6   <= prod[48:32];
            r_over6 <= r_over5;
            r_p7    <= n_p7;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_en) begin
            r_valid <= {r_valid[1:0], i_valid};
        end
    end

    assign o_valid = r_valid[2];
    assign o_adj   = r_p7;

endmodule

// ===== hw/rtl/hsv_hsv2rgb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hsv_hsv2rgb
// Build the sector factors, scale by value, round and place into RGB.
// ----------------------------------------------------------------------------
module hsv_hsv2rgb (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  logic              i_valid,
    input  hsv_pkg::t_hsv_adj i_adj,
    output logic              o_valid,
    output logic [7:0]        o_red,
    output logic [7:0]        o_green,
    output logic [7:0]        o_blue,
    output logic [7:0]        o_alpha
);

    logic [16:0]      r_fx, r_fy, r_fz;
    logic [19:0]      r_v;
    hsv_pkg::t_sector r_sec;
    logic [7:0]       r_alpha;
    logic [32:0]      t_y, t_z;
    logic [7:0]       pv, px, py, pz;
    logic [7:0]       r_red, r_green, r_blue, r_alpha_o;
    logic [7:0]       n_red, n_green, n_blue;
    logic [1:0]       r_valid;

    assign t_y = 33'(i_adj.frac) * 33'(i_adj.sat);
    assign t_z = 33'(hsv_pkg::Q16_ONE - 17'(i_adj.frac)) * 33'(i_adj.sat);

    function automatic logic [7:0] to_byte(input logic [19:0] v, input logic [16:0] f);
        logic [36:0] p;
        p = 37'(v) * 37'(f) + 37'(28'h8000000);
        to_byte = (p[36:28] > 9'd255) ? 8'd255 : p[35:28];
    endfunction

    always_comb begin
        logic [20:0] sv;
        sv = 21'(r_v) + 21'd2048;
        pv = (sv[20:12] > 9'd255) ? 8'd255 : sv[19:12];
        px = to_byte(r_v, r_fx);
        py = to_byte(r_v, r_fy);
        pz = to_byte(r_v, r_fz);
        case (r_sec)
            hsv_pkg::SEC_RY: begin n_red = pv; n_green = pz; n_blue = px; end
            hsv_pkg::SEC_YG: begin n_red = py; n_green = pv; n_blue = px; end
            hsv_pkg::SEC_GC: begin n_red = px; n_green = pv; n_blue = pz; end
            hsv_pkg::SEC_CB: begin n_red = px; n_green = py; n_blue = pv; end
            hsv_pkg::SEC_BM: begin n_red = pz; n_green = px; n_blue = pv; end
            default:         begin n_red = pv; n_green = px; n_blue = py; end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_fx      <= hsv_pkg::Q16_ONE - i_adj.sat;
            r_fy      <= hsv_pkg::Q16_ONE - t_y[32:16];
            r_fz      <= hsv_pkg::Q16_ONE - t_z[32:16];
            r_v       <= i_adj.v;
            r_sec     <= i_adj.sec;
            r_alpha   <= i_adj.alpha;
            r_red     <= n_red;
            r_green   <= n_green;
            r_blue    <= n_blue;
            r_alpha_o <= r_alpha;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_en) begin
            r_valid <= {r_valid[0], i_valid};
        end
    end

    assign o_valid = r_valid[1];
    assign o_red   = r_red;
    assign o_green = r_green;
    assign o_blue  = r_blue;
    assign o_alpha = r_alpha_o;

endmodule

// ===== hw/rtl/hsv_brightness_adjust.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hsv_brightness_adjust
// RGBA pixel brightness adjust through HSV, one pixel per clock unless stalled.
// ----------------------------------------------------------------------------
// Takes one pixel per clock while the output is not stalled. Each result
// passes through the 17-bit hue and saturation long divisions, spread over
// three stages, then the value scaling, reciprocal divide-by-255 and factor
// multipliers. The whole pipeline holds while the output is stalled; the
// input is ready whenever the output register is empty or being taken.
// Write adjust_mode and ratio only while the pipeline is empty.
module hsv_brightness_adjust (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic        i_cfg_index,
    input  logic [15:0] i_cfg_data,
    hsv_in_if.sink      i_pix,
    hsv_out_if.source   o_pix
);

    hsv_pkg::t_mode    r_mode;
    logic [15:0]       r_ratio;
    logic              en;
    logic              hsv_valid, adj_valid, out_valid;
    hsv_pkg::t_hsv     hsv;
    hsv_pkg::t_hsv_adj adj;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= hsv_pkg::MODE_DARKEN;
            r_ratio <= '0;
        end else if (i_cfg_we) begin
            case (hsv_pkg::t_cfg_index'(i_cfg_index))
                hsv_pkg::CFG_MODE:  r_mode  <= hsv_pkg::t_mode'(i_cfg_data[0]);
                hsv_pkg::CFG_RATIO: r_ratio <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // advance everything unless a finished pixel is held at the output
    assign en          = !out_valid || o_pix.ready;
    assign i_pix.ready = en;

    hsv_rgb2hsv u_rgb2hsv (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (i_pix.valid),
        .i_red   (i_pix.in_red),
        .i_green (i_pix.in_green),
        .i_blue  (i_pix.in_blue),
        .i_alpha (i_pix.in_alpha),
        .i_ratio (r_ratio),
        .o_valid (hsv_valid),
        .o_hsv   (hsv)
    );

    hsv_vadj u_vadj (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (hsv_valid),
        .i_hsv   (hsv),
        .i_mode  (r_mode),
        .o_valid (adj_valid),
        .o_adj   (adj)
    );

    hsv_hsv2rgb u_hsv2rgb (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (adj_valid),
        .i_adj   (adj),
        .o_valid (out_valid),
        .o_red   (o_pix.out_red),
        .o_green (o_pix.out_green),
        .o_blue  (o_pix.out_blue),
        .o_alpha (o_pix.out_alpha)
    );

    assign o_pix.valid = out_valid;

endmodule

// ===== hw/rtl/hsv_chk.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hsv_chk
// Port-level checks of the brightness block handshakes.
// ----------------------------------------------------------------------------
module hsv_chk (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_in_ready,
    input logic       i_out_valid,
    input logic       i_out_ready,
    input logic [7:0] i_out_red,
    input logic [7:0] i_out_alpha
);

    // an empty output never blocks the input
    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_out_valid |-> i_in_ready)
        else $error("input not ready while output is empty");

    // a stalled output blocks the input
    a_stall_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |-> !i_in_ready)
        else $error("input taken while output stalled");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=> (i_out_valid && $stable(i_out_red)
        && $stable(i_out_alpha)))
        else $error("stalled output changed");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("output valid after reset");

endmodule

bind hsv_brightness_adjust hsv_chk u_hsv_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_ready  (i_pix.ready),
    .i_out_valid (o_pix.valid),
    .i_out_ready (o_pix.ready),
    .i_out_red   (o_pix.out_red),
    .i_out_alpha (o_pix.out_alpha)
);

// ===== tb/sv/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the HSV brightness adjust block: directed corner
// pixels and random pixels over several mode/ratio settings, with random
// gaps on both channels and one long output stall.
// ----------------------------------------------------------------------------
module tb;

    typedef struct packed {
        logic [7:0] r;
        logic [7:0] g;
        logic [7:0] b;
        logic [7:0] a;
    } t_pixel;

    class pixel_scoreboard;
        t_pixel         pending[$];
        hsv_pkg::t_mode mode;
        logic [15:0]    ratio;
        int             errors;
        int             checked;

        function new();
            mode = hsv_pkg::MODE_DARKEN;
            ratio = 16'd0;
            errors = 0;
            checked = 0;
        endfunction

        function logic [7:0] scale_byte(logic [63:0] v, logic [63:0] factor);
            logic [63:0] p;
            p = (v * factor + 64'd134217728) >> 28;
            return (p > 64'd255) ? 8'd255 : p[7:0];
        endfunction

        function t_pixel adjust_pixel(t_pixel px);
            logic [63:0]      r, g, b, mx, mn, d, den, num, frac, s, v, adj, ex;
            logic [63:0]      fx, fy, fz;
            logic [7:0]       pv, pxv, py, pz;
            hsv_pkg::t_sector sec;
            t_pixel           res;
            r = px.r; g = px.g; b = px.b;
            mx = r; mn = r;
            if (g > mx) mx = g;
            if (b > mx) mx = b;
            if (g < mn) mn = g;
            if (b < mn) mn = b;
            d = mx - mn;
            sec = hsv_pkg::SEC_RY; num = 0; den = 1;
            if (d != 0) begin
                den = d;
                if (mx == r) begin
                    if (g >= b) begin sec = hsv_pkg::SEC_RY; num = g - b; end
                    else begin sec = hsv_pkg::SEC_MR; num = d - (b - g); end
                end else if (mx == g) begin
                    if (b >= r) begin sec = hsv_pkg::SEC_GC; num = b - r; end
                    else begin sec = hsv_pkg::SEC_YG; num = d - (r - b); end
                end else begin
                    if (r >= g) begin sec = hsv_pkg::SEC_BM; num = r - g; end
                    else begin sec = hsv_pkg::SEC_CB; num = d - (g - r); end
                end
            end
            frac = (num << 16) / den;
            if (frac >= 64'd65536) begin
                frac = 0;
                sec = (sec == hsv_pkg::SEC_MR) ? hsv_pkg::SEC_RY
                                               : hsv_pkg::t_sector'(sec + 3'd1);
            end
            s = (mx == 0) ? 0 : (d << 16) / mx;
            v = mx << 12;
            adj = (v * ratio) >> 12;
            if (mode == hsv_pkg::MODE_DARKEN) begin
                v = (adj >= v) ? 0 : v - adj;
            end else begin
                v = v + adj;
                if (v > 64'd1044480) begin
                    ex = ((v - 64'd1044480) << 4) / 255;
                    s = (ex >= s) ? 0 : s - ex;
                    v = 64'd1044480;
                end
            end
            fx = 65536 - s;
            fy = 65536 - ((frac * s) >> 16);
            fz = 65536 - (((65536 - frac) * s) >> 16);
            pv = scale_byte(v, 65536);
            pxv = scale_byte(v, fx);
            py = scale_byte(v, fy);
            pz = scale_byte(v, fz);
            case (sec)
                hsv_pkg::SEC_RY: begin res.r = pv;  res.g = pz;  res.b = pxv; end
                hsv_pkg::SEC_YG: begin res.r = py;  res.g = pv;  res.b = pxv; end
                hsv_pkg::SEC_GC: begin res.r = pxv; res.g = pv;  res.b = pz;  end
                hsv_pkg::SEC_CB: begin res.r = pxv; res.g = py;  res.b = pv;  end
                hsv_pkg::SEC_BM: begin res.r = pz;  res.g = pxv; res.b = pv;  end
                default:         begin res.r = pv;  res.g = pxv; res.b = py;  end
            endcase
            res.a = px.a;
            return res;
        endfunction

        function void note_input(t_pixel px);
            pending.push_back(adjust_pixel(px));
        endfunction

        function void check_result(t_pixel got);
            t_pixel exp_px;
            checked++;
            if (pending.size() == 0) begin
                $display("%0t: unexpected pixel %h", $realtime, got);
                errors++;
                return;
            end
            exp_px = pending.pop_front();
            if (got.r !== exp_px.r) begin
                $display("%0t: red expected %0d actual %0d", $realtime, exp_px.r, got.r);
                errors++;
            end
            if (got.g !== exp_px.g) begin
                $display("%0t: green expected %0d actual %0d", $realtime, exp_px.g, got.g);
                errors++;
            end
            if (got.b !== exp_px.b) begin
                $display("%0t: blue expected %0d actual %0d", $realtime, exp_px.b, got.b);
                errors++;
            end
            if (got.a !== exp_px.a) begin
                $display("%0t: alpha expected %0d actual %0d", $realtime, exp_px.a, got.a);
                errors++;
            end
        endfunction
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic        i_cfg_index;
    logic [15:0] i_cfg_data;

    hsv_in_if  pix_in ();
    hsv_out_if pix_out ();

    hsv_brightness_adjust dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_pix       (pix_in.sink),
        .o_pix       (pix_out.source)
    );

    pixel_scoreboard sb;
    int  sent;
    int  idle_cycles;
    bit  no_idle;
    bit  hold_off;
    bit  hold_done;

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    initial begin
        sb = new();
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_index = hsv_pkg::CFG_MODE;
        i_cfg_data = 16'd0;
        pix_in.valid = 1'b0;
        pix_in.in_red = 8'd0;
        pix_in.in_green = 8'd0;
        pix_in.in_blue = 8'd0;
        pix_in.in_alpha = 8'd0;
        pix_out.ready = 1'b0;
        sent = 0;
        idle_cycles = 0;
        no_idle = 1'b0;
        hold_off = 1'b0;
        hold_done = 1'b0;
    end

    // sample transfers on the output side
    always @(posedge i_clk) begin
        if (i_rst_n && pix_out.valid && pix_out.ready) begin
            sb.check_result({pix_out.out_red, pix_out.out_green,
                             pix_out.out_blue, pix_out.out_alpha});
        end
    end

    // receiver: random stalls, plus one long hold-off while input keeps coming
    initial begin
        int n;
        @(posedge i_clk);
        wait (i_rst_n);
        forever begin
            @(posedge i_clk);
            if (hold_off && !hold_done) begin
                pix_out.ready <= 1'b0;
                for (n = 0; n < 60; n++) @(posedge i_clk);
                hold_done = 1'b1;
            end
            pix_out.ready <= no_idle ? 1'b1 : ($urandom_range(99) >= 7);
        end
    end

    // watchdog: cycles without any transfer
    always @(posedge i_clk) begin
        if ((pix_in.valid && pix_in.ready) || (pix_out.valid && pix_out.ready)) begin
            idle_cycles <= 0;
        end else if (i_rst_n) begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles > 2000) begin
                $display("Some tests failed");
                $finish;
            end
        end
    end

    task automatic write_reg(hsv_pkg::t_cfg_index idx, logic [15:0] data);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == hsv_pkg::CFG_MODE) sb.mode = hsv_pkg::t_mode'(data[0]);
        else sb.ratio = data;
    endtask

    task automatic send_pixel(t_pixel px);
        if (!no_idle) begin
            while ($urandom_range(99) < 7) begin
                pix_in.valid <= 1'b0;
                @(posedge i_clk);
            end
        end
        pix_in.valid <= 1'b1;
        {pix_in.in_red, pix_in.in_green, pix_in.in_blue, pix_in.in_alpha} <= px;
        @(posedge i_clk);
        while (!pix_in.ready) @(posedge i_clk);
        sb.note_input(px);
        sent++;
    endtask

    task automatic drain();
        pix_in.valid <= 1'b0;
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (12) @(posedge i_clk);
    endtask

    function automatic t_pixel random_pixel();
        t_pixel px;
        case ($urandom_range(3))
            0: begin
                px.r = 8'($urandom_range(255));
                px.g = px.r;
                px.b = ($urandom_range(1)) ? px.r : 8'($urandom_range(255));
            end
            1: begin
                px.r = $urandom_range(1) ? 8'd255 : 8'd0;
                px.g = 8'($urandom_range(255));
                px.b = $urandom_range(1) ? 8'd255 : 8'd0;
            end
            default: px = $urandom;
        endcase
        px.a = 8'($urandom);
        return px;
    endfunction

    initial begin
        t_pixel corners[$];
        logic [15:0] ratios[$];
        int p, k;
        corners = '{
            32'h00000000, 32'hFFFFFFFF, 32'h808080A5, 32'hFF000012,
            32'h00FF0034, 32'h0000FF56, 32'hFFFF0078, 32'h00FFFF9A,
            32'hFF00FFBC, 32'hFF8000DE, 32'h80FF00F0, 32'h00FF800F,
            32'h0080FF01, 32'h8000FF02, 32'hFF008003, 32'hC8C80A44,
            32'h0AC8C855, 32'hC80AC866, 32'h01000077, 32'hFE010288,
            32'h7F807E99, 32'h10FF10AA, 32'h0102FFBB
        };
        ratios = '{16'd0, 16'hFFFF, 16'd4096, 16'd2048, 16'd8192, 16'd1};
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (p = 0; p < 12; p++) begin
            write_reg(hsv_pkg::CFG_MODE, {15'd0, p[0]});
            write_reg(hsv_pkg::CFG_RATIO, (p < 6) ? ratios[p] : 16'($urandom));
            foreach (corners[c]) send_pixel(corners[c]);
            no_idle = (p == 3);
            if (p == 5) hold_off = 1'b1;
            for (k = 0; k < 110; k++) begin
                send_pixel(random_pixel());
            end
            drain();
        end
        $display("Covered %0d pixels over 12 mode/ratio settings, both modes,", sent);
        $display("ratio extremes 0 and 0xFFFF, greys, ties and a long output stall.");
        if (sb.errors == 0 && sb.pending.size() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end
endmodule
